// ----- sv/assert_macros.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");
// Expression must never be true out of reset.
`define ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, prop)
`define ASSERT_NEVER(label, expr)
`endif
`endif

// ----- sv/wsd_pkg.sv -----
// Types and codes shared by the WebSocket frame deframer.
package wsd_pkg;

    // Parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT_HI  = 3'd2;
    localparam logic [2:0] PH_EXT_LO  = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_HALT    = 3'd6;

    // Result kinds
    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_CLOSE     = 3'd2;
    localparam logic [2:0] KIND_PING      = 3'd3;
    localparam logic [2:0] KIND_LONG_LEN  = 3'd4;
    localparam logic [2:0] KIND_TOO_LONG  = 3'd5;

    // Opcodes and header fields
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;
    localparam logic [15:0] MASK_KEY_BYTES = 16'd4;

    typedef struct packed {
        logic [2:0]       phase;
        logic [3:0]       opcode;
        logic             mask_present;
        logic [15:0]      payload_length;
        logic [15:0]      byte_count;
        logic [3:0][7:0]  mask_key;
        logic             skipping;
    } parse_state_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        is_text;
        logic        last_byte;
        logic [15:0] frame_length;
    } result_t;

endpackage

// ----- sv/wsd_parse.sv -----
// Next-state and result logic for one received byte.
module wsd_parse (
    input  wsd_pkg::parse_state_t state,
    input  logic [7:0]            rx_byte,
    input  logic [15:0]           max_payload,
    output wsd_pkg::parse_state_t state_next,
    output logic                  res_valid,
    output wsd_pkg::result_t      res
);
    import wsd_pkg::*;

    logic        hdr_done;
    logic [6:0]  len7;
    logic [15:0] count_inc;
    logic [7:0]  unmasked;
    logic        last;
    logic        is_text;

    assign len7      = rx_byte[6:0];
    assign count_inc = state.byte_count + 16'd1;
    assign unmasked  = state.mask_present ?
                       (rx_byte ^ state.mask_key[state.byte_count[1:0]]) : rx_byte;
    assign last      = (count_inc == state.payload_length);
    assign is_text   = (state.opcode == OP_TEXT);

    always_comb begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;
        hdr_done   = 1'b0;

        // Advance the header/payload walk
        unique case (state.phase)
            PH_HDR0: begin
                state_next.opcode   = rx_byte[3:0];
                state_next.skipping = (rx_byte[3:0] == OP_CLOSE) ||
                                      (rx_byte[3:0] == OP_PING);
                state_next.phase    = PH_HDR1;
            end
            PH_HDR1: begin
                state_next.mask_present = rx_byte[7];
                state_next.byte_count   = '0;
                if (len7 == LEN_EXT64) begin
                    state_next.phase = PH_HALT;
                    res_valid        = 1'b1;
                    res.kind         = KIND_LONG_LEN;
                end else if (len7 == LEN_EXT16) begin
                    state_next.payload_length = '0;
                    state_next.phase          = PH_EXT_HI;
                end else begin
                    state_next.payload_length = {9'd0, len7};
                    if (rx_byte[7]) begin
                        state_next.phase = PH_MASK;
                    end else begin
                        hdr_done = 1'b1;
                    end
                end
            end
            PH_EXT_HI: begin
                state_next.payload_length = {rx_byte, 8'd0};
                state_next.phase          = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                state_next.payload_length = {state.payload_length[15:8], rx_byte};
                if (state.mask_present) begin
                    state_next.byte_count = '0;
                    state_next.phase      = PH_MASK;
                end else begin
                    hdr_done = 1'b1;
                end
            end
            PH_MASK: begin
                state_next.mask_key[state.byte_count[1:0]] = rx_byte;
                state_next.byte_count = count_inc;
                hdr_done = (count_inc >= MASK_KEY_BYTES);
            end
            PH_PAYLOAD: begin
                state_next.byte_count = count_inc;
                if (last) begin
                    state_next.phase    = PH_HDR0;
                    state_next.skipping = 1'b0;
                end
                if (!state.skipping) begin
                    res_valid          = 1'b1;
                    res.kind           = KIND_PAYLOAD;
                    res.data_byte      = unmasked;
                    res.is_text        = is_text;
                    res.last_byte      = last;
                    res.frame_length   = state.payload_length;
                end
            end
            default: begin
                // halted or unused code: drop the byte
                state_next = state;
            end
        endcase

        // Finish the header: control event, length check or empty frame
        if (hdr_done) begin
            state_next.byte_count = '0;
            if (state_next.skipping) begin
                res_valid        = 1'b1;
                res.kind         = (state_next.opcode == OP_CLOSE) ? KIND_CLOSE : KIND_PING;
                res.frame_length = state_next.payload_length;
                if (state_next.payload_length == '0) begin
                    state_next.skipping = 1'b0;
                    state_next.phase    = PH_HDR0;
                end else begin
                    state_next.phase = PH_PAYLOAD;
                end
            end else if (state_next.payload_length > max_payload) begin
                state_next.phase = PH_HALT;
                res_valid        = 1'b1;
                res.kind         = KIND_TOO_LONG;
                res.frame_length = state_next.payload_length;
            end else if (state_next.payload_length == '0) begin
                state_next.phase = PH_HDR0;
                res_valid        = 1'b1;
                res.kind         = KIND_EMPTY;
                res.is_text      = (state_next.opcode == OP_TEXT);
            end else begin
                state_next.phase = PH_PAYLOAD;
            end
        end
    end

endmodule

// ----- sv/websocket_frame_deframer.sv -----
// Top level of the WebSocket frame deframer: registers, handshakes and config.
//
// Usage: received stream bytes enter on s_rx_byte with s_valid/s_ready; each
// transfer is one byte. Results leave on the m_ channel with m_valid/m_ready:
// one per payload byte of a data frame (unmasked), one per empty data frame,
// one per close or ping header (their payload is consumed silently), and one
// error result on a 64-bit length or a data length above max_payload, after
// which the deframer ignores all input until reset.
// Timing: a byte is captured in the input register at its transfer, parsed from
// that register, and its result is loaded into the result register once that
// register is free. Throughput is one byte per cycle while the receiver does not
// stall, set by the single parse stage that updates the frame state once per byte.
// max_payload is written through cfg_wr_en/cfg_wr_data; it is sampled only
// when a data header completes. Reset (aresetn low, synchronous) returns the
// parser to the first header byte and sets max_payload to 65535.
// When the receiver stalls, the result register holds and the input register
// fills; s_ready then drops until m_ready returns.
module websocket_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic        m_is_text,
    output logic        m_last_byte,
    output logic [15:0] m_frame_length,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import wsd_pkg::*;

    `include "assert_macros.svh"

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic [15:0]  max_payload_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         m_valid_reg;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_next;
    logic         out_free;
    logic         advance;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    wsd_parse u_parse (
        .state       (state_reg),
        .rx_byte     (in_byte_reg),
        .max_payload (max_payload_reg),
        .state_next  (state_next),
        .res_valid   (res_valid_next),
        .res         (res_next)
    );

    // Hold the configured length limit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Advance the frame state one byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_HDR0, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Load or drain the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= advance && res_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid_next) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = res_reg.kind;
    assign m_data_byte    = res_reg.data_byte;
    assign m_is_text      = res_reg.is_text;
    assign m_last_byte    = res_reg.last_byte;
    assign m_frame_length = res_reg.frame_length;

    // Halt is sticky until reset
    `ASSERT_PROP(a_halt_sticky, state_reg.phase == PH_HALT |=> state_reg.phase == PH_HALT)
    // Payload phase always has bytes left to take
    `ASSERT_NEVER(a_payload_nonempty, (state_reg.phase == PH_PAYLOAD) && (state_reg.payload_length == '0))
    `ASSERT_NEVER(a_count_in_range, (state_reg.phase == PH_PAYLOAD) && (state_reg.byte_count >= state_reg.payload_length))
    // A full input register behind a stalled result blocks new transfers
    `ASSERT_NEVER(a_stall_blocks, in_valid_reg && m_valid_reg && !m_ready && s_ready)

endmodule

// ----- sim/tb_websocket_frame_deframer.sv -----
// Self-checking testbench for the WebSocket frame deframer, with a built-in frame predictor.
module tb_websocket_frame_deframer;
    import wsd_pkg::*;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam int unsigned RUN_LIMIT = 600000;
    localparam int unsigned MAX_REPORTS = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [7:0]  m_data_byte;
    logic        m_is_text;
    logic        m_last_byte;
    logic [15:0] m_frame_length;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;

    // Bytes waiting for transfer and results the deframer still owes
    logic [7:0]  tx_bytes[$];
    result_t     due_results[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned kind_count[0:5];
    int unsigned limits_used = 1;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          no_idle;

    // Shadow of the frame parser state and the payload limit
    logic [15:0] max_len = MAX_PAYLOAD_RESET;
    logic [2:0]  ph = PH_HDR0;
    logic [3:0]  cur_op = 4'h0;
    logic        masked = 1'b0;
    logic [15:0] plen = 16'h0000;
    logic [15:0] bcount = 16'h0000;
    logic [7:0]  key[0:3] = '{default: 8'h00};
    logic        skip_ctl = 1'b0;

    websocket_frame_deframer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_is_text     (m_is_text),
        .m_last_byte   (m_last_byte),
        .m_frame_length(m_frame_length),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Header complete: emit the control event, the empty-frame event or the length error
    function automatic bit close_header(output result_t r);
        r = '0;
        bcount = '0;
        if (skip_ctl) begin
            r.kind = (cur_op == OP_CLOSE) ? KIND_CLOSE : KIND_PING;
            r.frame_length = plen;
            if (plen == 16'd0) begin
                skip_ctl = 1'b0;
                ph = PH_HDR0;
            end else begin
                ph = PH_PAYLOAD;
            end
            return 1'b1;
        end
        if (plen > max_len) begin
            ph = PH_HALT;
            r.kind = KIND_TOO_LONG;
            r.frame_length = plen;
            return 1'b1;
        end
        if (plen == 16'd0) begin
            ph = PH_HDR0;
            r.kind = KIND_EMPTY;
            r.is_text = (cur_op == OP_TEXT);
            return 1'b1;
        end
        ph = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // Advance the shadow parser by one received byte; return 1 when a result is due
    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        logic [7:0] d;
        bit is_last;
        r = '0;
        case (ph)
            PH_HDR0: begin
                cur_op = b[3:0];
                skip_ctl = (cur_op == OP_CLOSE) || (cur_op == OP_PING);
                ph = PH_HDR1;
                return 1'b0;
            end
            PH_HDR1: begin
                masked = b[7];
                bcount = '0;
                if (b[6:0] == LEN_EXT64) begin
                    ph = PH_HALT;
                    r.kind = KIND_LONG_LEN;
                    return 1'b1;
                end
                if (b[6:0] == LEN_EXT16) begin
                    plen = '0;
                    ph = PH_EXT_HI;
                    return 1'b0;
                end
                plen = {9'd0, b[6:0]};
                if (masked) begin
                    ph = PH_MASK;
                    return 1'b0;
                end
                return close_header(r);
            end
            PH_EXT_HI: begin
                plen = {b, 8'h00};
                ph = PH_EXT_LO;
                return 1'b0;
            end
            PH_EXT_LO: begin
                plen[7:0] = b;
                if (masked) begin
                    bcount = '0;
                    ph = PH_MASK;
                    return 1'b0;
                end
                return close_header(r);
            end
            PH_MASK: begin
                key[bcount[1:0]] = b;
                bcount = bcount + 16'd1;
                if (bcount >= MASK_KEY_BYTES) return close_header(r);
                return 1'b0;
            end
            PH_PAYLOAD: begin
                d = masked ? (b ^ key[bcount[1:0]]) : b;
                bcount = bcount + 16'd1;
                is_last = (bcount == plen);
                if (skip_ctl) begin
                    if (is_last) begin
                        skip_ctl = 1'b0;
                        ph = PH_HDR0;
                    end
                    return 1'b0;
                end
                if (is_last) ph = PH_HDR0;
                r.kind = KIND_PAYLOAD;
                r.data_byte = d;
                r.is_text = (cur_op == OP_TEXT);
                r.last_byte = is_last;
                r.frame_length = plen;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endfunction

    // Queue one frame; body sets how many bytes follow the header
    task automatic queue_frame(input logic [3:0] op, input int unsigned len,
                               input bit mask_it, input bit ext_len, input int unsigned body);
        logic [15:0] len16;
        len16 = 16'(len);
        push_byte({4'($urandom_range(0, 15)), op});
        push_byte({mask_it, ext_len ? LEN_EXT16 : len16[6:0]});
        if (ext_len) begin
            push_byte(len16[15:8]);
            push_byte(len16[7:0]);
        end
        if (mask_it) repeat (4) push_byte(8'($urandom));
        repeat (body) push_byte(8'($urandom));
    endtask

    // Queue well-formed frames with random opcode, length, mask and content
    task automatic queue_traffic(input int unsigned budget);
        int unsigned start;
        int unsigned sel;
        int unsigned len;
        logic [3:0]  op;
        bit          ctl;
        start = bytes_queued;
        while (bytes_queued - start < budget) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) op = OP_TEXT;
            else if (sel < 60) op = OP_BINARY;
            else if (sel < 72) op = OP_CLOSE;
            else if (sel < 84) op = OP_PING;
            else op = 4'($urandom_range(0, 15));
            sel = $urandom_range(0, 99);
            if (sel < 55) len = $urandom_range(0, 8);
            else if (sel < 85) len = $urandom_range(9, 125);
            else len = $urandom_range(126, 200);
            ctl = (op == OP_CLOSE) || (op == OP_PING);
            if (!ctl && len > max_len) len = $urandom_range(0, max_len);
            queue_frame(op, len, 1'($urandom_range(0, 1)),
                        (len > 125) || ($urandom_range(0, 7) == 0), len);
        end
    endtask

    // Wait until every byte is through and every result has arrived
    task automatic wait_drained();
        while (tx_bytes.size() != 0 || s_valid || due_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        max_len = value;
        limits_used++;
    endtask

    assign no_idle = (bytes_accepted >= 120) && (bytes_accepted < 220);

    // Run the cycle counter and stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still due",
                     cycle_count, due_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Hold off the receiver once for a long stretch so the input side backs up
    always @(posedge aclk) begin
        if (!hold_done && results_checked == 40) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Offer queued bytes, predict results on each input transfer
    always @(posedge aclk) begin : drive_bytes
        result_t res;
        bit      has_res;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                bytes_accepted <= bytes_accepted + 1;
                has_res = deframe_byte(s_rx_byte, res);
                if (has_res) due_results.push_back(res);
            end
            if (!s_valid || s_ready) begin
                if (tx_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= 25)) begin
                    s_valid <= 1'b1;
                    s_rx_byte <= tx_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= 25);
            if (m_valid && m_ready) begin
                got = {m_kind, m_data_byte, m_is_text, m_last_byte, m_frame_length};
                if (got.kind <= KIND_TOO_LONG) kind_count[got.kind]++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected result kind=%0d data=%02h text=%0d last=%0d len=%0d",
                                 got.kind, got.data_byte, got.is_text, got.last_byte,
                                 got.frame_length);
                end else begin
                    want = due_results.pop_front();
                    results_checked <= results_checked + 1;
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.is_text !== want.is_text || got.last_byte !== want.last_byte ||
                        got.frame_length !== want.frame_length) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"Mismatch: expected kind=%0d data=%02h text=%0d last=%0d ",
                                      "len=%0d, got kind=%0d data=%02h text=%0d last=%0d len=%0d"},
                                     want.kind, want.data_byte, want.is_text, want.last_byte,
                                     want.frame_length, got.kind, got.data_byte, got.is_text,
                                     got.last_byte, got.frame_length);
                    end
                end
            end
        end
    end

    // Stimulus: directed frames, random traffic under several limits, closing error
    initial begin : stimulus
        int unsigned len;
        int unsigned waited;
        bit          long_code;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed frames at the reset limit
        queue_frame(OP_TEXT, 1, 1'b0, 1'b0, 1);
        queue_frame(OP_BINARY, 2, 1'b1, 1'b0, 2);
        queue_frame(OP_TEXT, 0, 1'b0, 1'b0, 0);
        queue_frame(OP_CLOSE, 2, 1'b0, 1'b0, 2);
        queue_frame(OP_PING, 0, 1'b1, 1'b0, 0);
        queue_frame(OP_TEXT, 1, 1'b1, 1'b1, 1);
        queue_frame(OP_CONT, 0, 1'b0, 1'b1, 0);
        queue_traffic(80);
        // Extended length on a ping, skipped silently
        queue_frame(OP_PING, 150, 1'b1, 1'b1, 150);
        wait_drained();

        // Zero limit: only empty data frames pass, control frames are exempt
        write_limit(16'd0);
        queue_traffic(40);
        wait_drained();

        write_limit(16'($urandom_range(2, 400)));
        queue_traffic(60);
        wait_drained();

        write_limit(16'd1);
        queue_traffic(30);
        wait_drained();

        // Finish with one error frame, then bytes that must be ignored
        write_limit(16'($urandom_range(0, 300)));
        queue_traffic(30);
        long_code = 1'($urandom_range(0, 1));
        if (long_code) begin
            push_byte(8'($urandom));
            push_byte({1'($urandom_range(0, 1)), LEN_EXT64});
        end else begin
            len = max_len + $urandom_range(1, 50);
            if ($urandom_range(0, 3) == 0) len = 65535;
            queue_frame($urandom_range(0, 1) ? OP_TEXT : OP_BINARY, len,
                        1'($urandom_range(0, 1)), (len > 125) || $urandom_range(0, 1), 40);
        end
        repeat (20) push_byte(8'($urandom));

        // Drain with a bound, then allow stray results to show up
        waited = 0;
        while ((tx_bytes.size() != 0 || s_valid || due_results.size() != 0) && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (10) @(posedge aclk);
        if (due_results.size() != 0) begin
            mismatches++;
            $display("%0d expected results never arrived", due_results.size());
        end

        $display("Checked %0d results from %0d bytes: %0d payload, %0d empty, %0d close, %0d ping",
                 results_checked, bytes_accepted, kind_count[0], kind_count[1], kind_count[2],
                 kind_count[3]);
        $display("Used %0d payload limits including 0 and 65535; ended on %s error, %0d mismatches",
                 limits_used, long_code ? "64-bit length" : "too-long", mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/wsd_pkg.sv
sv/wsd_parse.sv
sv/websocket_frame_deframer.sv
sim/tb_websocket_frame_deframer.sv
